### rtl/core/gaol_pkg.sv
// Package with the shared constants and types of the group address object lookup.
`default_nettype none

package gaol_pkg;

    localparam int ADDRESS_DEPTH     = 256;
    localparam int ASSOCIATION_DEPTH = 256;

    localparam int ADDR_IDX_W  = $clog2(ADDRESS_DEPTH);
    localparam int ASSOC_IDX_W = $clog2(ASSOCIATION_DEPTH);

    localparam int KIND_W    = 2;
    localparam int COUNT_W   = 8;
    localparam int GADDR_W   = 16;
    localparam int OBJ_W     = 8;
    localparam int ENTRY_W   = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_WRITE_ADDRESS     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE_ASSOCIATION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP            = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSOCIATION_COUNT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR_SCAN,
        ST_ASSOC_SCAN,
        ST_RESULT
    } state_t;

endpackage

`default_nettype wire

### rtl/core/gaol_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module gaol_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/group_address_object_lookup.sv
// Top level of the group address object lookup with its scan sequencer and tables.
//
// Items arrive on the request channel (req_valid, req_stall). A write item stores an
// address entry or an association pair and gives no result. A lookup item makes the
// sequencer walk the address table and, on an address hit, the association table, one
// entry per cycle through a registered RAM read and a single shared equality compare.
// An address hit records its one-based position and ends the address scan; a miss
// scans up to the address count. The association scan does the same against its count.
// The result beat is then presented on the response channel (rsp_valid, rsp_stall). The
// block accepts no new request beat while a lookup is in progress or its response waits.
// A stalled response holds its beat until rsp_stall falls.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets the two
// entry counts and is always ready. Reset clears the counts and the sequencer; table
// contents are undefined until written.
`default_nettype none

module group_address_object_lookup (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [gaol_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [gaol_pkg::COUNT_W-1:0]      cfg_data,
    input  wire logic                              req_valid,
    output logic                                   req_stall,
    input  wire logic [gaol_pkg::KIND_W-1:0]       kind,
    input  wire logic [gaol_pkg::COUNT_W-1:0]      entry_slot,
    input  wire logic [gaol_pkg::GADDR_W-1:0]      group_address,
    input  wire logic [gaol_pkg::COUNT_W-1:0]      linked_index,
    input  wire logic [gaol_pkg::OBJ_W-1:0]        object_number,
    output logic                                   rsp_valid,
    input  wire logic                              rsp_stall,
    output logic                                   address_found,
    output logic      [gaol_pkg::COUNT_W-1:0]      address_position,
    output logic                                   object_found,
    output logic      [gaol_pkg::OBJ_W-1:0]        object_result
);

    import gaol_pkg::*;

    localparam logic [COUNT_W:0]   ADDR_DEPTH_EXT  = (COUNT_W+1)'(ADDRESS_DEPTH);
    localparam logic [COUNT_W:0]   ASSOC_DEPTH_EXT = (COUNT_W+1)'(ASSOCIATION_DEPTH);
    localparam logic [COUNT_W-1:0] ADDR_DEPTH_CNT  = COUNT_W'(ADDRESS_DEPTH);
    localparam logic [COUNT_W-1:0] ASSOC_DEPTH_CNT = COUNT_W'(ASSOCIATION_DEPTH);

    state_t state_reg, state_next;

    logic [COUNT_W-1:0] address_count_reg, association_count_reg;
    logic [COUNT_W-1:0] idx_reg, idx_next;
    logic               dv_reg, dv_next;
    logic [GADDR_W-1:0] key_reg, key_next;
    logic [COUNT_W-1:0] pos_reg, pos_next;
    logic               afound_reg, afound_next;
    logic               ofound_reg, ofound_next;
    logic [OBJ_W-1:0]   result_reg, result_next;

    logic               req_accept;
    logic               addr_we, assoc_we;
    logic [ENTRY_W-1:0] addr_rdata, assoc_rdata;
    logic [COUNT_W-1:0] addr_lim, assoc_lim;
    logic [ENTRY_W-1:0] cmp_a, cmp_b;
    logic               hit;

    assign cfg_ready  = 1'b1;
    assign req_accept = req_valid && !req_stall;

    assign addr_we  = req_accept && (kind == KIND_WRITE_ADDRESS)
                      && ({1'b0, entry_slot} < ADDR_DEPTH_EXT);
    assign assoc_we = req_accept && (kind == KIND_WRITE_ASSOCIATION)
                      && ({1'b0, entry_slot} < ASSOC_DEPTH_EXT);

    assign addr_lim  = ({1'b0, address_count_reg} < ADDR_DEPTH_EXT)
                       ? address_count_reg : ADDR_DEPTH_CNT;
    assign assoc_lim = ({1'b0, association_count_reg} < ASSOC_DEPTH_EXT)
                       ? association_count_reg : ASSOC_DEPTH_CNT;

    gaol_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ADDRESS_DEPTH)
    ) u_addr_ram (
        .clk   (clk),
        .we    (addr_we),
        .waddr (entry_slot[ADDR_IDX_W-1:0]),
        .wdata (group_address),
        .raddr (idx_reg[ADDR_IDX_W-1:0]),
        .rdata (addr_rdata)
    );

    gaol_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (ASSOCIATION_DEPTH)
    ) u_assoc_ram (
        .clk   (clk),
        .we    (assoc_we),
        .waddr (entry_slot[ASSOC_IDX_W-1:0]),
        .wdata ({linked_index, object_number}),
        .raddr (idx_reg[ASSOC_IDX_W-1:0]),
        .rdata (assoc_rdata)
    );

    // The one equality compare is shared by both table scans.
    always_comb
    begin
        if (state_reg == ST_ADDR_SCAN)
        begin
            cmp_a = addr_rdata;
            cmp_b = key_reg;
        end
        else
        begin
            cmp_a = {{(ENTRY_W-COUNT_W){1'b0}}, assoc_rdata[ENTRY_W-1:OBJ_W]};
            cmp_b = {{(ENTRY_W-COUNT_W){1'b0}}, pos_reg};
        end
        hit = dv_reg && (cmp_a == cmp_b);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (kind == KIND_LOOKUP))
                begin
                    state_next = ST_ADDR_SCAN;
                end
            end
            ST_ADDR_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_ASSOC_SCAN;
                end
                else if (idx_reg >= addr_lim)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_ASSOC_SCAN:
            begin
                if (hit || (idx_reg >= assoc_lim))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!rsp_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall = (state_reg != ST_IDLE);
        rsp_valid = (state_reg == ST_RESULT);
    end

    // An entry read issued in one cycle is compared in the next; idx_reg then
    // already holds its one-based position.
    always_comb
    begin
        idx_next    = idx_reg;
        dv_next     = 1'b0;
        key_next    = key_reg;
        pos_next    = pos_reg;
        afound_next = afound_reg;
        ofound_next = ofound_reg;
        result_next = result_reg;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                key_next = group_address;
            end
            ST_ADDR_SCAN:
            begin
                if (hit)
                begin
                    afound_next = 1'b1;
                    pos_next    = idx_reg;
                    idx_next    = '0;
                end
                else if (idx_reg < addr_lim)
                begin
                    idx_next = idx_reg + 1'b1;
                    dv_next  = 1'b1;
                end
                else
                begin
                    afound_next = 1'b0;
                    pos_next    = '0;
                    ofound_next = 1'b0;
                    result_next = '0;
                end
            end
            ST_ASSOC_SCAN:
            begin
                if (hit)
                begin
                    ofound_next = 1'b1;
                    result_next = assoc_rdata[OBJ_W-1:0];
                end
                else if (idx_reg < assoc_lim)
                begin
                    idx_next = idx_reg + 1'b1;
                    dv_next  = 1'b1;
                end
                else
                begin
                    ofound_next = 1'b0;
                    result_next = '0;
                end
            end
            default:
            begin
                dv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            dv_reg                <= 1'b0;
            address_count_reg     <= '0;
            association_count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            dv_reg    <= dv_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ADDRESS_COUNT:     address_count_reg     <= cfg_data;
                    CFG_ASSOCIATION_COUNT: association_count_reg <= cfg_data;
                    default:               address_count_reg     <= address_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        key_reg    <= key_next;
        pos_reg    <= pos_next;
        afound_reg <= afound_next;
        ofound_reg <= ofound_next;
        result_reg <= result_next;
    end

    assign address_found    = afound_reg;
    assign address_position = pos_reg;
    assign object_found     = ofound_reg;
    assign object_result    = result_reg;

    a_object_needs_address: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && object_found |-> address_found)
        else $error("object reported without an address match");

    a_miss_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !address_found |->
            (address_position == '0) && !object_found && (object_result == '0))
        else $error("address miss carries nonzero result fields");

    a_lookup_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_accept && (kind == KIND_LOOKUP) |=> state_reg == ST_ADDR_SCAN)
        else $error("accepted lookup did not start the address scan");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ADDR_SCAN |-> idx_reg <= addr_lim)
        else $error("address scan ran past its limit");

endmodule

`default_nettype wire

### verif/lookup_checker.sv
`timescale 1ns / 100ps
// Checker that watches the lookup block's channels, predicts each lookup answer and compares.
module lookup_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [gaol_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [gaol_pkg::COUNT_W-1:0]   cfg_data,
    input  wire logic                           req_valid,
    input  wire logic                           req_stall,
    input  wire logic [gaol_pkg::KIND_W-1:0]    kind,
    input  wire logic [gaol_pkg::COUNT_W-1:0]   entry_slot,
    input  wire logic [gaol_pkg::GADDR_W-1:0]   group_address,
    input  wire logic [gaol_pkg::COUNT_W-1:0]   linked_index,
    input  wire logic [gaol_pkg::OBJ_W-1:0]     object_number,
    input  wire logic                           rsp_valid,
    input  wire logic                           rsp_stall,
    input  wire logic                           address_found,
    input  wire logic [gaol_pkg::COUNT_W-1:0]   address_position,
    input  wire logic                           object_found,
    input  wire logic [gaol_pkg::OBJ_W-1:0]     object_result,
    output int                                  fail_count,
    output int                                  pending
);
    import gaol_pkg::*;

    typedef struct packed {
        logic               address_found;
        logic [COUNT_W-1:0] position;
        logic               object_found;
        logic [OBJ_W-1:0]   object_number;
    } answer_t;

    logic [GADDR_W-1:0] address_table [ADDRESS_DEPTH];
    logic [COUNT_W-1:0] link_table [ASSOCIATION_DEPTH];
    logic [OBJ_W-1:0]   object_table [ASSOCIATION_DEPTH];
    logic [COUNT_W-1:0] address_limit = '0;
    logic [COUNT_W-1:0] association_limit = '0;
    answer_t            answers_due [$];

    initial begin
        fail_count = 0;
        pending = 0;
    end

    function automatic answer_t resolve_object(input logic [GADDR_W-1:0] target);
        answer_t a;
        int      i;
        a = '0;
        for (i = 0; i < ADDRESS_DEPTH && i < int'(address_limit) && !a.address_found; i++) begin
            if (address_table[i] == target) begin
                a.address_found = 1'b1;
                a.position = COUNT_W'(i + 1);
            end
        end
        if (a.address_found) begin
            for (i = 0; i < ASSOCIATION_DEPTH && i < int'(association_limit) && !a.object_found;
                 i++) begin
                if (link_table[i] == a.position) begin
                    a.object_found = 1'b1;
                    a.object_number = object_table[i];
                end
            end
        end
        return a;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Every response beat is compared against the oldest lookup still waiting.
    always @(posedge clk) begin
        answer_t want;
        if (rst_n) begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("response beat with no lookup waiting");
                end
                else begin
                    want = answers_due.pop_front();
                    if (address_found !== want.address_found)
                        report_mismatch($sformatf("address_found %b, predicted %b",
                                                  address_found, want.address_found));
                    if (address_position !== want.position)
                        report_mismatch($sformatf("address_position %0d, predicted %0d",
                                                  address_position, want.position));
                    if (object_found !== want.object_found)
                        report_mismatch($sformatf("object_found %b, predicted %b",
                                                  object_found, want.object_found));
                    if (object_result !== want.object_number)
                        report_mismatch($sformatf("object_result %0d, predicted %0d",
                                                  object_result, want.object_number));
                end
            end
            if (req_valid === 1'b1 && req_stall === 1'b0) begin
                case (kind)
                    KIND_WRITE_ADDRESS:
                        address_table[entry_slot] = group_address;
                    KIND_WRITE_ASSOCIATION: begin
                        link_table[entry_slot] = linked_index;
                        object_table[entry_slot] = object_number;
                    end
                    KIND_LOOKUP:
                        answers_due.push_back(resolve_object(group_address));
                    default: ;
                endcase
            end
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
                case (cfg_index)
                    CFG_ADDRESS_COUNT:     address_limit = cfg_data;
                    CFG_ASSOCIATION_COUNT: association_limit = cfg_data;
                    default: ;
                endcase
            end
            pending = answers_due.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Testbench top with clock, reset, stimulus and the verdict for the group address object lookup.
module testbench;
    import gaol_pkg::*;

    localparam int ITEM_TARGET   = 1150;
    localparam int BIG_PHASE     = 5;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 600;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [COUNT_W-1:0]   cfg_data = '0;
    logic                 req_valid = 1'b0;
    logic                 req_stall;
    logic [KIND_W-1:0]    kind = '0;
    logic [COUNT_W-1:0]   entry_slot = '0;
    logic [GADDR_W-1:0]   group_address = '0;
    logic [COUNT_W-1:0]   linked_index = '0;
    logic [OBJ_W-1:0]     object_number = '0;
    logic                 rsp_valid;
    logic                 rsp_stall = 1'b0;
    logic                 address_found;
    logic [COUNT_W-1:0]   address_position;
    logic                 object_found;
    logic [OBJ_W-1:0]     object_result;

    int   mismatches;
    int   outstanding;
    logic calm = 1'b0;
    logic hold_go = 1'b0;

    logic [GADDR_W-1:0] address_shadow [ADDRESS_DEPTH];
    bit                 address_written [ADDRESS_DEPTH];
    bit                 association_written [ASSOCIATION_DEPTH];
    int sent, address_writes, association_writes, lookups, ignored, settings;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    group_address_object_lookup u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .kind             (kind),
        .entry_slot       (entry_slot),
        .group_address    (group_address),
        .linked_index     (linked_index),
        .object_number    (object_number),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .address_found    (address_found),
        .address_position (address_position),
        .object_found     (object_found),
        .object_result    (object_result)
    );

    lookup_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .kind             (kind),
        .entry_slot       (entry_slot),
        .group_address    (group_address),
        .linked_index     (linked_index),
        .object_number    (object_number),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .address_found    (address_found),
        .address_position (address_position),
        .object_found     (object_found),
        .object_result    (object_result),
        .fail_count       (mismatches),
        .pending          (outstanding)
    );

    // The receiver stalls at random, except for one long hold-off and the calm stretch.
    initial begin
        int hold_left;
        bit hold_taken;
        hold_left = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else begin
                rsp_stall <= !calm && ($urandom_range(0, 99) < 31);
            end
        end
    end

    initial begin
        #8_000_000;
        $display("FAIL group_address_object_lookup");
        $finish;
    end

    function automatic logic [GADDR_W-1:0] pick_address();
        if ($urandom_range(0, 3) == 0)
            return 16'h0F00 | GADDR_W'($urandom_range(0, 3));
        return GADDR_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_link(input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return COUNT_W'($urandom_range(1, span > 0 ? span : 1));
        if (r < 85)
            return '0;
        return COUNT_W'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [KIND_W-1:0] k, input logic [COUNT_W-1:0] slot,
                             input logic [GADDR_W-1:0] ga, input logic [COUNT_W-1:0] li,
                             input logic [OBJ_W-1:0] ob);
        while (!calm && $urandom_range(0, 99) < 31) begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        kind <= k;
        entry_slot <= slot;
        group_address <= ga;
        linked_index <= li;
        object_number <= ob;
        @(negedge clk);
        while (req_stall) @(negedge clk);
        @(posedge clk);
        sent++;
        case (k)
            KIND_WRITE_ADDRESS: begin
                address_shadow[slot] = ga;
                address_written[slot] = 1'b1;
                address_writes++;
            end
            KIND_WRITE_ASSOCIATION: begin
                association_written[slot] = 1'b1;
                association_writes++;
            end
            KIND_LOOKUP: lookups++;
            default: ignored++;
        endcase
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [COUNT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        while (!cfg_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_counts(input int na, input int nb);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_register(CFG_ADDRESS_COUNT, COUNT_W'(na));
        write_register(CFG_ASSOCIATION_COUNT, COUNT_W'(nb));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    initial begin
        int                 na, nb, na_cfg, nb_cfg, body, r, s, j, phase;
        logic [KIND_W-1:0]  k;
        logic [COUNT_W-1:0] slot, li;
        logic [GADDR_W-1:0] ga;
        logic [OBJ_W-1:0]   ob;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // With both counts at zero nothing can be found.
        set_counts(0, 0);
        send_item(KIND_LOOKUP, 8'd0, 16'hFFFF, 8'd0, 8'd0);

        // Duplicate addresses, an index-zero pair, duplicate links and the top slot.
        send_item(KIND_WRITE_ADDRESS, 8'd0, 16'h0000, 8'd255, 8'd255);
        send_item(KIND_WRITE_ADDRESS, 8'd1, 16'hFFFF, 8'd0, 8'd0);
        send_item(KIND_WRITE_ADDRESS, 8'd2, 16'h1234, 8'd0, 8'd0);
        send_item(KIND_WRITE_ADDRESS, 8'd3, 16'h1234, 8'd0, 8'd0);
        send_item(KIND_WRITE_ADDRESS, 8'd255, 16'hABCD, 8'd0, 8'd0);
        send_item(KIND_WRITE_ASSOCIATION, 8'd0, 16'h0000, 8'd0, 8'hFF);
        send_item(KIND_WRITE_ASSOCIATION, 8'd1, 16'hFFFF, 8'd2, 8'h00);
        send_item(KIND_WRITE_ASSOCIATION, 8'd2, 16'h0000, 8'd1, 8'hAB);
        send_item(KIND_WRITE_ASSOCIATION, 8'd3, 16'h0000, 8'd2, 8'h55);
        send_item(KIND_WRITE_ASSOCIATION, 8'd4, 16'h0000, 8'd255, 8'h7F);
        send_item(KIND_WRITE_ASSOCIATION, 8'd255, 16'h0000, 8'd255, 8'hFF);
        send_item(KIND_UNUSED, 8'd255, 16'hFFFF, 8'd255, 8'hFF);

        set_counts(4, 5);
        send_item(KIND_LOOKUP, 8'd0, 16'h0000, 8'd0, 8'd0);
        send_item(KIND_LOOKUP, 8'd0, 16'hFFFF, 8'd0, 8'd0);
        send_item(KIND_LOOKUP, 8'd0, 16'h1234, 8'd0, 8'd0);
        send_item(KIND_LOOKUP, 8'd0, 16'h5555, 8'd0, 8'd0);
        send_item(KIND_LOOKUP, 8'd0, 16'hABCD, 8'd0, 8'd0);

        set_counts(4, 0);
        send_item(KIND_LOOKUP, 8'd0, 16'h0000, 8'd0, 8'd0);

        phase = 0;
        while (sent < ITEM_TARGET) begin
            if (phase == BIG_PHASE) begin
                na = 255;
                nb = 255;
            end
            else begin
                na = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
                nb = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24);
            end
            for (s = 0; s < na; s++)
                if (!address_written[s] || $urandom_range(0, 3) == 0)
                    send_item(KIND_WRITE_ADDRESS, COUNT_W'(s), pick_address(),
                              COUNT_W'($urandom_range(0, 255)), OBJ_W'($urandom_range(0, 255)));
            for (s = 0; s < nb; s++)
                if (!association_written[s] || $urandom_range(0, 3) == 0)
                    send_item(KIND_WRITE_ASSOCIATION, COUNT_W'(s),
                              GADDR_W'($urandom_range(0, 65535)), pick_link(na),
                              OBJ_W'($urandom_range(0, 255)));
            na_cfg = (phase != BIG_PHASE && $urandom_range(0, 3) == 0) ? $urandom_range(0, na) : na;
            nb_cfg = (phase != BIG_PHASE && $urandom_range(0, 3) == 0) ? $urandom_range(0, nb) : nb;
            set_counts(na_cfg, nb_cfg);
            if (phase == 3)
                calm <= 1'b1;
            body = (phase == BIG_PHASE) ? 12 : $urandom_range(30, 80);
            for (j = 0; j < body; j++) begin
                if (phase == 2 && j == 5)
                    hold_go <= 1'b1;
                if (phase == 4 && j == body / 2)
                    drain();
                r = $urandom_range(0, 99);
                slot = COUNT_W'($urandom_range(0, 255));
                ga = GADDR_W'($urandom_range(0, 65535));
                li = COUNT_W'($urandom_range(0, 255));
                ob = OBJ_W'($urandom_range(0, 255));
                if (r < 12) begin
                    k = KIND_WRITE_ADDRESS;
                    ga = pick_address();
                end
                else if (r < 22) begin
                    k = KIND_WRITE_ASSOCIATION;
                    li = pick_link(na_cfg);
                end
                else if (r < 25) begin
                    k = KIND_UNUSED;
                end
                else begin
                    k = KIND_LOOKUP;
                    if (na_cfg > 0 && r < 80)
                        ga = address_shadow[$urandom_range(0, na_cfg - 1)];
                    else if (r >= 95)
                        ga = (r % 2 == 0) ? 16'hFFFF : 16'h0000;
                end
                send_item(k, slot, ga, li, ob);
            end
            if (phase == 3)
                calm <= 1'b0;
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Run covered %0d items (%0d address writes, %0d association writes, %0d lookups, %0d ignored) under %0d count settings up to 255 entries.",
                 sent, address_writes, association_writes, lookups, ignored, settings);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS group_address_object_lookup");
        else
            $display("FAIL group_address_object_lookup");
        $finish;
    end

endmodule
